// ===== sv/tbo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_pkg: shared widths, types and index tables
// Fixed-point widths for the triangle/box overlap pipeline, derived from the
// coordinate width so every internal product is exact.
// ----------------------------------------------------------------------------
package tbo_pkg;

   localparam int COORD_BITS = 21;
   localparam int FIELD_W    = 63;
   localparam int NUM_FIELDS = 5;

   localparam int REQ_TDATA_W = ((NUM_FIELDS * FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 8;

   // vertex relative to box centre, edge, half size
   localparam int VREL_W = COORD_BITS + 1;
   localparam int EDGE_W = COORD_BITS + 2;
   localparam int HALF_W = COORD_BITS;

   // edge-axis tests
   localparam int PROD_W  = EDGE_W + VREL_W;
   localparam int RPROD_W = EDGE_W + HALF_W;
   localparam int CMP_W   = PROD_W + 2;

   // plane test
   localparam int NPROD_W   = 2 * EDGE_W;
   localparam int N_W       = NPROD_W + 1;
   localparam int M_W       = COORD_BITS + 2;
   localparam int LOW_SPLIT = (N_W + 1) / 2;
   localparam int NH_W      = N_W - LOW_SPLIT;
   localparam int PL_W      = LOW_SPLIT + 1 + M_W;
   localparam int PH_W      = NH_W + M_W;
   localparam int SL_W      = PL_W + 2;
   localparam int SH_W      = PH_W + 2;
   localparam int DOT_W     = SH_W + LOW_SPLIT + 1;

   // register stages, output register included
   localparam int STAGES = 9;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [VREL_W-1:0]     vrel_type;
   typedef logic signed [EDGE_W-1:0]     edge_type;
   typedef logic        [HALF_W-1:0]     half_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic        [RPROD_W-1:0]    rprod_type;
   typedef logic signed [CMP_W-1:0]      cmp_type;
   typedef logic signed [NPROD_W-1:0]    nprod_type;
   typedef logic signed [N_W-1:0]        norm_type;
   typedef logic signed [M_W-1:0]        mvec_type;
   typedef logic signed [PL_W-1:0]       pl_type;
   typedef logic signed [PH_W-1:0]       ph_type;
   typedef logic signed [SL_W-1:0]       sl_type;
   typedef logic signed [SH_W-1:0]       sh_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic        [STAGES-1:0]     stage_load_type;

   // cyclic successor / predecessor of an axis or vertex index
   localparam int NEXT3 [3] = '{1, 2, 0};
   localparam int PREV3 [3] = '{2, 0, 1};

   // vertex pair projected for each edge (row) and box axis (column)
   localparam int PAIR_A [3][3] = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}};
   localparam int PAIR_B [3][3] = '{'{2, 2, 2}, '{2, 2, 1}, '{1, 1, 2}};

   function automatic logic [EDGE_W-1:0] edge_mag(edge_type e);
      return e[EDGE_W-1] ? EDGE_W'(-e) : EDGE_W'(e);
   endfunction

endpackage
`default_nettype wire

// ===== sv/triangle_box_overlap_test_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_unit: triangle / axis-aligned box overlap test
// Separating-axis test on fixed-point coordinates, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one box (centre, half sizes) and one triangle
//    (three vertices) per request; each field holds x, y, z coordinates of
//    COORD_BITS bits, x lowest. Accepted when req_tvalid && req_tready.
//  - Response channel (rsp_*): one response per request, in order;
//    rsp_tdata[0] is 1 when the triangle and box overlap (touching counts).
//  - Throughput: one request per clock until a stalled response side fills
//    the pipeline. Depth: nine register stages, the last being the response
//    register; the depth is set by the plane test (normal product, corner
//    pick, split dot-product multiply, sums, final wide add).
//  - Stalls: valid bits travel with each stage; a stage accepts new data
//    when it is empty or its successor moves, so bubbles are squeezed out and
//    requests are still taken while a response waits, until every stage is
//    full. Nothing is dropped or repeated.
//  - Reset (synchronous, active high) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_unit import tbo_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // fields from bit 0: box_centre, box_half_size, vertex_zero, vertex_one,
   // vertex_two (63 bits each), zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fields from bit 0: overlaps, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   stage_load_type valid_ff;
   stage_load_type valid_in;
   stage_load_type load;

   vrel_type vtx   [3][3];
   edge_type edges [3][3];
   half_type half  [3];
   logic     face_sep;
   logic     box_sep;
   logic     plane_sep;
   logic     overlaps_ff;

   // a stage loads when empty or when the stage after it moves on
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (load[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign req_tready = load[0];

   // stages 0-1
   tbo_prep u_prep (
      .clock         (clock),
      .load          (load),
      .box_centre    (req_tdata[0*FIELD_W +: FIELD_W]),
      .box_half_size (req_tdata[1*FIELD_W +: FIELD_W]),
      .vertex_zero   (req_tdata[2*FIELD_W +: FIELD_W]),
      .vertex_one    (req_tdata[3*FIELD_W +: FIELD_W]),
      .vertex_two    (req_tdata[4*FIELD_W +: FIELD_W]),
      .vtx_ff        (vtx),
      .edge_ff       (edges),
      .half_ff       (half),
      .face_sep_ff   (face_sep)
   );

   // stages 2-7, edge axes and face flag
   tbo_axes u_axes (
      .clock      (clock),
      .load       (load),
      .vtx        (vtx),
      .edges      (edges),
      .half       (half),
      .face_sep   (face_sep),
      .box_sep_ff (box_sep)
   );

   // stages 2-7, plane test
   tbo_plane u_plane (
      .clock        (clock),
      .load         (load),
      .vtx          (vtx),
      .edges        (edges),
      .half         (half),
      .plane_sep_ff (plane_sep)
   );

   // stage 8: response register
   always_ff @(posedge clock) begin
      if (load[STAGES-1]) overlaps_ff <= !(box_sep || plane_sep);
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = RSP_TDATA_W'(overlaps_ff);

   // only a blocked response can hold off requests
   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

   // back-pressure reaches the input only once every stage holds a request
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("request stalled with a bubble in the pipeline");

   // reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule
`default_nettype wire

// ===== sv/tbo_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_prep: unpack, recentre, edges and box-face test
// Stage 0 moves the vertices relative to the box centre, stage 1 forms the
// edges and the three box-face extent tests.
// ----------------------------------------------------------------------------
module tbo_prep import tbo_pkg::*; (
   input  logic               clock,
   input  stage_load_type     load,
   input  logic [FIELD_W-1:0] box_centre,
   input  logic [FIELD_W-1:0] box_half_size,
   input  logic [FIELD_W-1:0] vertex_zero,
   input  logic [FIELD_W-1:0] vertex_one,
   input  logic [FIELD_W-1:0] vertex_two,
   output vrel_type           vtx_ff  [3][3],
   output edge_type           edge_ff [3][3],
   output half_type           half_ff [3],
   output logic               face_sep_ff
);

   vrel_type rel_ff [3][3];
   vrel_type rel_in [3][3];
   half_type h0_ff  [3];
   half_type h0_in  [3];
   edge_type edge_in [3][3];
   logic     face_sep_in;
   logic [FIELD_W-1:0] vfield [3];

   assign vfield[0] = vertex_zero;
   assign vfield[1] = vertex_one;
   assign vfield[2] = vertex_two;

   always_comb begin
      for (int q = 0; q < 3; q++) begin
         h0_in[q] = box_half_size[q*COORD_BITS +: COORD_BITS];
         for (int t = 0; t < 3; t++) begin
            rel_in[t][q] = VREL_W'(coord_type'(vfield[t][q*COORD_BITS +: COORD_BITS]))
                         - VREL_W'(coord_type'(box_centre[q*COORD_BITS +: COORD_BITS]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rel_ff <= rel_in;
         h0_ff  <= h0_in;
      end
   end

   // e0 = v1 - v0, e1 = v2 - v1, e2 = v0 - v2
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int q = 0; q < 3; q++) begin
            edge_in[k][q] = EDGE_W'(rel_ff[NEXT3[k]][q]) - EDGE_W'(rel_ff[k][q]);
         end
      end
   end

   // triangle extent against each box face pair
   always_comb begin
      vrel_type lo;
      vrel_type hi;
      logic signed [VREL_W:0] hs;
      logic signed [VREL_W:0] los;
      logic signed [VREL_W:0] his;
      face_sep_in = 1'b0;
      for (int q = 0; q < 3; q++) begin
         lo = rel_ff[0][q];
         hi = rel_ff[0][q];
         if (rel_ff[1][q] < lo) lo = rel_ff[1][q];
         if (rel_ff[1][q] > hi) hi = rel_ff[1][q];
         if (rel_ff[2][q] < lo) lo = rel_ff[2][q];
         if (rel_ff[2][q] > hi) hi = rel_ff[2][q];
         hs  = (VREL_W+1)'(h0_ff[q]);
         los = (VREL_W+1)'(lo);
         his = (VREL_W+1)'(hi);
         if (los > hs || his < -hs) face_sep_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         vtx_ff      <= rel_ff;
         edge_ff     <= edge_in;
         half_ff     <= h0_ff;
         face_sep_ff <= face_sep_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tbo_axes.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_axes: edge-cross-axis separation tests, every triangle edge crossed with every box axis
// Stage 2 multiplies, stage 3 forms projections and radii, stage 4 compares;
// the result, merged with the box-face flag, is delayed to stage 7.
// ----------------------------------------------------------------------------
module tbo_axes import tbo_pkg::*; (
   input  logic           clock,
   input  stage_load_type load,
   input  vrel_type       vtx  [3][3],
   input  edge_type       edges [3][3],
   input  half_type       half [3],
   input  logic           face_sep,
   output logic           box_sep_ff
);

   prod_type  pa1_ff [3][3], pa2_ff [3][3], pb1_ff [3][3], pb2_ff [3][3];
   prod_type  pa1_in [3][3], pa2_in [3][3], pb1_in [3][3], pb2_in [3][3];
   rprod_type r1_ff  [3][3], r2_ff  [3][3];
   rprod_type r1_in  [3][3], r2_in  [3][3];
   cmp_type   pa_ff  [3][3], pb_ff  [3][3], rad_ff [3][3];
   cmp_type   pa_in  [3][3], pb_in  [3][3], rad_in [3][3];
   logic      edge_sep_in;
   logic      face2_ff, face3_ff, sep4_ff, sep5_ff, sep6_ff;

   // products for edge k crossed with box axis a
   always_comb begin
      int i;
      int j;
      int va;
      int vb;
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            i  = NEXT3[a];
            j  = PREV3[a];
            va = PAIR_A[k][a];
            vb = PAIR_B[k][a];
            pa1_in[k][a] = PROD_W'(edges[k][j]) * PROD_W'(vtx[va][i]);
            pa2_in[k][a] = PROD_W'(edges[k][i]) * PROD_W'(vtx[va][j]);
            pb1_in[k][a] = PROD_W'(edges[k][j]) * PROD_W'(vtx[vb][i]);
            pb2_in[k][a] = PROD_W'(edges[k][i]) * PROD_W'(vtx[vb][j]);
            r1_in[k][a]  = RPROD_W'(edge_mag(edges[k][j])) * RPROD_W'(half[i]);
            r2_in[k][a]  = RPROD_W'(edge_mag(edges[k][i])) * RPROD_W'(half[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         pa1_ff   <= pa1_in;
         pa2_ff   <= pa2_in;
         pb1_ff   <= pb1_in;
         pb2_ff   <= pb2_in;
         r1_ff    <= r1_in;
         r2_ff    <= r2_in;
         face2_ff <= face_sep;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            pa_in[k][a]  = CMP_W'(pa1_ff[k][a]) - CMP_W'(pa2_ff[k][a]);
            pb_in[k][a]  = CMP_W'(pb1_ff[k][a]) - CMP_W'(pb2_ff[k][a]);
            rad_in[k][a] = CMP_W'(r1_ff[k][a]) + CMP_W'(r2_ff[k][a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         rad_ff   <= rad_in;
         face3_ff <= face2_ff;
      end
   end

   // interval of the two projections against [-r, r]
   always_comb begin
      cmp_type lo;
      cmp_type hi;
      edge_sep_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            lo = (pa_ff[k][a] < pb_ff[k][a]) ? pa_ff[k][a] : pb_ff[k][a];
            hi = (pa_ff[k][a] < pb_ff[k][a]) ? pb_ff[k][a] : pa_ff[k][a];
            if (lo > rad_ff[k][a] || hi < -rad_ff[k][a]) edge_sep_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) sep4_ff    <= edge_sep_in | face3_ff;
      if (load[5]) sep5_ff    <= sep4_ff;
      if (load[6]) sep6_ff    <= sep5_ff;
      if (load[7]) box_sep_ff <= sep6_ff;
   end

endmodule
`default_nettype wire

// ===== sv/tbo_plane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_plane: triangle plane against box test
// Normal n = e0 x e1, pick the box corners nearest and farthest along n, and
// take the exact sign of n . corner with the normal split in two halves.
// ----------------------------------------------------------------------------
module tbo_plane import tbo_pkg::*; (
   input  logic           clock,
   input  stage_load_type load,
   input  vrel_type       vtx  [3][3],
   input  edge_type       edges [3][3],
   input  half_type       half [3],
   output logic           plane_sep_ff
);

   nprod_type na_ff [3], nb_ff [3], na_in [3], nb_in [3];
   mvec_type  mpos2_ff [3], mneg2_ff [3], mpos_in [3], mneg_in [3];
   norm_type  norm3_ff [3], norm_in [3];
   mvec_type  mpos3_ff [3], mneg3_ff [3];
   norm_type  norm4_ff [3];
   mvec_type  mmin_ff [3], mmax_ff [3], mmin_in [3], mmax_in [3];
   pl_type    plmin_ff [3], plmax_ff [3], plmin_in [3], plmax_in [3];
   ph_type    phmin_ff [3], phmax_ff [3], phmin_in [3], phmax_in [3];
   sl_type    slmin_ff, slmax_ff;
   sh_type    shmin_ff, shmax_ff;
   dot_type   dot_min, dot_max;

   // stage 2: cross product terms and both corner offsets
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         na_in[q]   = NPROD_W'(edges[0][NEXT3[q]]) * NPROD_W'(edges[1][PREV3[q]]);
         nb_in[q]   = NPROD_W'(edges[0][PREV3[q]]) * NPROD_W'(edges[1][NEXT3[q]]);
         mpos_in[q] = M_W'(half[q]) - M_W'(vtx[0][q]);
         mneg_in[q] = -M_W'(half[q]) - M_W'(vtx[0][q]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         na_ff    <= na_in;
         nb_ff    <= nb_in;
         mpos2_ff <= mpos_in;
         mneg2_ff <= mneg_in;
      end
   end

   // stage 3: normal
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         norm_in[q] = N_W'(na_ff[q]) - N_W'(nb_ff[q]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         norm3_ff <= norm_in;
         mpos3_ff <= mpos2_ff;
         mneg3_ff <= mneg2_ff;
      end
   end

   // stage 4: corner choice by sign of each normal component
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         if (norm3_ff[q] > 0) begin
            mmin_in[q] = mneg3_ff[q];
            mmax_in[q] = mpos3_ff[q];
         end else begin
            mmin_in[q] = mpos3_ff[q];
            mmax_in[q] = mneg3_ff[q];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         norm4_ff <= norm3_ff;
         mmin_ff  <= mmin_in;
         mmax_ff  <= mmax_in;
      end
   end

   // stage 5: partial products, low half unsigned, high half signed
   always_comb begin
      logic signed [LOW_SPLIT:0] nl;
      logic signed [NH_W-1:0]    nh;
      for (int q = 0; q < 3; q++) begin
         nl = (LOW_SPLIT+1)'(norm4_ff[q][LOW_SPLIT-1:0]);
         nh = norm4_ff[q][N_W-1:LOW_SPLIT];
         plmin_in[q] = PL_W'(nl) * PL_W'(mmin_ff[q]);
         plmax_in[q] = PL_W'(nl) * PL_W'(mmax_ff[q]);
         phmin_in[q] = PH_W'(nh) * PH_W'(mmin_ff[q]);
         phmax_in[q] = PH_W'(nh) * PH_W'(mmax_ff[q]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         plmin_ff <= plmin_in;
         plmax_ff <= plmax_in;
         phmin_ff <= phmin_in;
         phmax_ff <= phmax_in;
      end
   end

   // stage 6: sums per half
   always_ff @(posedge clock) begin
      if (load[6]) begin
         slmin_ff <= SL_W'(plmin_ff[0]) + SL_W'(plmin_ff[1]) + SL_W'(plmin_ff[2]);
         slmax_ff <= SL_W'(plmax_ff[0]) + SL_W'(plmax_ff[1]) + SL_W'(plmax_ff[2]);
         shmin_ff <= SH_W'(phmin_ff[0]) + SH_W'(phmin_ff[1]) + SH_W'(phmin_ff[2]);
         shmax_ff <= SH_W'(phmax_ff[0]) + SH_W'(phmax_ff[1]) + SH_W'(phmax_ff[2]);
      end
   end

   // stage 7: exact dot products; separated if near corner above the plane
   // or far corner below it
   assign dot_min = (DOT_W'(shmin_ff) <<< LOW_SPLIT) + DOT_W'(slmin_ff);
   assign dot_max = (DOT_W'(shmax_ff) <<< LOW_SPLIT) + DOT_W'(slmax_ff);

   always_ff @(posedge clock) begin
      if (load[7]) plane_sep_ff <= (dot_min > 0) || (dot_max < 0);
   end

endmodule
`default_nettype wire

// ===== tb/sv/triangle_box_overlap_test_unit_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_unit_test: self-checking bench for the overlap unit
// Streams box/triangle requests through the pipeline with bursty input and a
// stalling response side, predicts each overlap flag with exact wide integer
// arithmetic and compares every response in order.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_unit_test;
   import tbo_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4 * STAGES;
   localparam int HOLD_AFTER   = 60;    // requests seen before the long stall
   localparam int LONG_HOLD    = 200;   // cycles the receiver holds off

   // coordinate extremes
   localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int CMIN = -(1 << (COORD_BITS - 1));
   localparam int HMAX = (1 << COORD_BITS) - 1;
   localparam int HTOP = 1 << (COORD_BITS - 1);

   // field order inside a request
   localparam int FLD_CENTRE = 0;
   localparam int FLD_HALF   = 1;
   localparam int FLD_V0     = 2;
   localparam int FLD_V1     = 3;
   localparam int FLD_V2     = 4;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   typedef logic [REQ_TDATA_W-1:0] req_word_type;
   typedef logic [FIELD_W-1:0]     field_type;
   typedef logic signed [127:0]    wide_type;   // wide enough for every product exactly
   typedef wide_type               vec3_type [3];

   typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_TIGHT} rx_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the overlap flag per request, checks responses
   // -------------------------------------------------------------------------
   class overlap_scoreboard;
      bit overlap_q[$];
      int requests_noted;
      int overlap_seen;
      int separated_seen;
      int mismatches;

      function new();
         requests_noted = 0;
         overlap_seen   = 0;
         separated_seen = 0;
         mismatches     = 0;
      endfunction

      function wide_type coord_s(field_type f, int k);
         logic signed [COORD_BITS-1:0] raw;
         wide_type r;
         raw = f[k*COORD_BITS +: COORD_BITS];
         r = wide_type'(raw);
         return r;
      endfunction

      function wide_type coord_u(field_type f, int k);
         logic [COORD_BITS-1:0] raw;
         wide_type r;
         raw = f[k*COORD_BITS +: COORD_BITS];
         r = wide_type'(raw);
         return r;
      endfunction

      function wide_type mag(wide_type x);
         return (x < 0) ? -x : x;
      endfunction

      // vertex projected on (edge) x (box axis)
      function wide_type project(vec3_type e, vec3_type v, int ax);
         case (ax)
            AXIS_X:  return e[AXIS_Z] * v[AXIS_Y] - e[AXIS_Y] * v[AXIS_Z];
            AXIS_Y:  return e[AXIS_X] * v[AXIS_Z] - e[AXIS_Z] * v[AXIS_X];
            default: return e[AXIS_Y] * v[AXIS_X] - e[AXIS_X] * v[AXIS_Y];
         endcase
      endfunction

      function wide_type box_radius(vec3_type e, vec3_type h, int ax);
         case (ax)
            AXIS_X:  return mag(e[AXIS_Z]) * h[AXIS_Y] + mag(e[AXIS_Y]) * h[AXIS_Z];
            AXIS_Y:  return mag(e[AXIS_Z]) * h[AXIS_X] + mag(e[AXIS_X]) * h[AXIS_Z];
            default: return mag(e[AXIS_Y]) * h[AXIS_X] + mag(e[AXIS_X]) * h[AXIS_Y];
         endcase
      endfunction

      function bit edge_separates(vec3_type e, vec3_type h, int ax, vec3_type va,
                                  vec3_type vb);
         wide_type pa, pb, lo, hi, r;
         pa = project(e, va, ax);
         pb = project(e, vb, ax);
         lo = (pa < pb) ? pa : pb;
         hi = (pa < pb) ? pb : pa;
         r  = box_radius(e, h, ax);
         return (lo > r) || (hi < -r);
      endfunction

      function wide_type dot3(vec3_type a, vec3_type b);
         return a[AXIS_X] * b[AXIS_X] + a[AXIS_Y] * b[AXIS_Y] + a[AXIS_Z] * b[AXIS_Z];
      endfunction

      function bit predict_overlap(req_word_type d);
         field_type f [NUM_FIELDS];
         vec3_type c, h, v0, v1, v2, e0, e1, e2, nrm, vmin, vmax;
         wide_type lo, hi;
         for (int k = 0; k < NUM_FIELDS; k++) f[k] = d[k*FIELD_W +: FIELD_W];
         for (int q = 0; q < 3; q++) begin
            c[q]  = coord_s(f[FLD_CENTRE], q);
            h[q]  = coord_u(f[FLD_HALF], q);
            v0[q] = coord_s(f[FLD_V0], q) - c[q];
            v1[q] = coord_s(f[FLD_V1], q) - c[q];
            v2[q] = coord_s(f[FLD_V2], q) - c[q];
         end
         for (int q = 0; q < 3; q++) begin
            e0[q] = v1[q] - v0[q];
            e1[q] = v2[q] - v1[q];
            e2[q] = v0[q] - v2[q];
         end
         // edge x box-axis tests, every edge against every box axis
         if (edge_separates(e0, h, AXIS_X, v0, v2) || edge_separates(e0, h, AXIS_Y, v0, v2) ||
             edge_separates(e0, h, AXIS_Z, v1, v2))
            return 1'b0;
         if (edge_separates(e1, h, AXIS_X, v0, v2) || edge_separates(e1, h, AXIS_Y, v0, v2) ||
             edge_separates(e1, h, AXIS_Z, v0, v1))
            return 1'b0;
         if (edge_separates(e2, h, AXIS_X, v0, v1) || edge_separates(e2, h, AXIS_Y, v0, v1) ||
             edge_separates(e2, h, AXIS_Z, v1, v2))
            return 1'b0;
         // box faces against triangle extent
         for (int q = 0; q < 3; q++) begin
            lo = v0[q];
            hi = v0[q];
            if (v1[q] < lo) lo = v1[q];
            if (v1[q] > hi) hi = v1[q];
            if (v2[q] < lo) lo = v2[q];
            if (v2[q] > hi) hi = v2[q];
            if (lo > h[q] || hi < -h[q]) return 1'b0;
         end
         // triangle plane against box; exact width, so only the sign matters
         nrm[AXIS_X] = e0[AXIS_Y] * e1[AXIS_Z] - e0[AXIS_Z] * e1[AXIS_Y];
         nrm[AXIS_Y] = e0[AXIS_Z] * e1[AXIS_X] - e0[AXIS_X] * e1[AXIS_Z];
         nrm[AXIS_Z] = e0[AXIS_X] * e1[AXIS_Y] - e0[AXIS_Y] * e1[AXIS_X];
         for (int q = 0; q < 3; q++) begin
            if (nrm[q] > 0) begin
               vmin[q] = -h[q] - v0[q];
               vmax[q] = h[q] - v0[q];
            end else begin
               vmin[q] = h[q] - v0[q];
               vmax[q] = -h[q] - v0[q];
            end
         end
         if (dot3(nrm, vmin) > 0) return 1'b0;
         return dot3(nrm, vmax) >= 0;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      function void note_request(req_word_type d);
         overlap_q.push_back(predict_overlap(d));
         requests_noted++;
      endfunction

      task check_response(logic [RSP_TDATA_W-1:0] d);
         bit want;
         if (overlap_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = overlap_q.pop_front();
         if (d[0] !== want)
            report_mismatch($sformatf("overlaps got %b want %b", d[0], want));
         if (want) overlap_seen++;
         else      separated_seen++;
      endtask

      function int pending();
         return overlap_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and signals
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   req_word_type req_tdata;      // box_centre, box_half_size, vertex_zero/one/two, zero pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // overlaps, zero pad

   overlap_scoreboard sb;
   int cycle_count = 0;
   int burst_left  = 0;
   int directed_sent = 0;

   triangle_box_overlap_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("simulation failed");
         $finish;
      end
   end

   // monitor: both channels sampled at the edge, before the drivers update
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Request building
   // -------------------------------------------------------------------------
   function automatic field_type pack_xyz(int x, int y, int z);
      return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
   endfunction

   function automatic req_word_type make_request(field_type c, field_type h, field_type v0,
                                                 field_type v1, field_type v2);
      return {{(REQ_TDATA_W - NUM_FIELDS*FIELD_W){1'b0}}, v2, v1, v0, h, c};
   endfunction

   // Mix: fully random bits, extreme coordinates, degenerate triangles and
   // triangles scattered around the box at a random scale (the bulk).
   function automatic req_word_type random_request();
      int kind, s, span, lim, k;
      int pt [NUM_FIELDS][3];
      int dir [3];
      field_type f [NUM_FIELDS];
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         for (int fl = 0; fl < NUM_FIELDS; fl++) f[fl] = field_type'({$urandom, $urandom});
      end else begin
         if (kind < 25) begin
            for (int fl = 0; fl < NUM_FIELDS; fl++)
               for (int q = 0; q < 3; q++)
                  if (fl == FLD_HALF)
                     case ($urandom_range(0, 4))
                        0:       pt[fl][q] = 0;
                        1:       pt[fl][q] = HMAX;
                        2:       pt[fl][q] = HTOP;
                        3:       pt[fl][q] = HTOP - 1;
                        default: pt[fl][q] = 1;
                     endcase
                  else
                     case ($urandom_range(0, 4))
                        0:       pt[fl][q] = CMIN;
                        1:       pt[fl][q] = CMAX;
                        2:       pt[fl][q] = 0;
                        3:       pt[fl][q] = -1;
                        default: pt[fl][q] = 1;
                     endcase
         end else begin
            // scale chosen so every point stays inside the coordinate range
            s    = $urandom_range(0, 17);
            span = 1 << s;
            lim  = (1 << (COORD_BITS - 1)) - 5 * span - 1;
            for (int q = 0; q < 3; q++) begin
               pt[FLD_CENTRE][q] = int'($urandom_range(0, 2 * lim)) - lim;
               pt[FLD_HALF][q]   = $urandom_range(0, span);
               pt[FLD_V0][q]     = pt[FLD_CENTRE][q] + int'($urandom_range(0, 4 * span)) - 2 * span;
            end
            if ($urandom_range(0, 3) == 0)   // anchor first vertex inside the box
               for (int q = 0; q < 3; q++)
                  pt[FLD_V0][q] = pt[FLD_CENTRE][q] + int'($urandom_range(0, 2 * pt[FLD_HALF][q]))
                                  - pt[FLD_HALF][q];
            if (kind < 45) begin
               // zero-area: collinear points, or a single point
               k = int'($urandom_range(0, 4)) - 2;
               for (int q = 0; q < 3; q++)
                  dir[q] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
               for (int q = 0; q < 3; q++) begin
                  pt[FLD_V1][q] = pt[FLD_V0][q] + dir[q];
                  pt[FLD_V2][q] = pt[FLD_V0][q] + k * dir[q];
               end
            end else begin
               for (int q = 0; q < 3; q++) begin
                  pt[FLD_V1][q] = pt[FLD_CENTRE][q] + int'($urandom_range(0, 4 * span)) - 2 * span;
                  pt[FLD_V2][q] = pt[FLD_CENTRE][q] + int'($urandom_range(0, 4 * span)) - 2 * span;
               end
            end
         end
         for (int fl = 0; fl < NUM_FIELDS; fl++)
            f[fl] = pack_xyz(pt[fl][0], pt[fl][1], pt[fl][2]);
      end
      return make_request(f[FLD_CENTRE], f[FLD_HALF], f[FLD_V0], f[FLD_V1], f[FLD_V2]);
   endfunction

   // -------------------------------------------------------------------------
   // Sender: bursts of random length, random gaps in between
   // -------------------------------------------------------------------------
   task offer_request(req_word_type d);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    gap = 0;
            2, 3:    gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 20);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task send_directed(field_type c, field_type h, field_type v0, field_type v1,
                      field_type v2);
      offer_request(make_request(c, h, v0, v1, v2));
      directed_sent++;
   endtask

   // Hand-picked cases: range extremes, touching, degenerate, plane-only,
   // half sizes with the top bit set, nonzero centre.
   task run_directed();
      field_type ones, zero3;
      ones  = '1;
      zero3 = '0;
      send_directed(zero3, zero3, zero3, zero3, zero3);
      send_directed(ones, ones, ones, ones, ones);
      // largest box, triangle spread to the range limits
      send_directed(zero3, pack_xyz(HMAX, HMAX, HMAX), pack_xyz(CMIN, CMIN, CMIN),
                    pack_xyz(CMAX, CMIN, CMIN), pack_xyz(CMIN, CMAX, CMAX));
      // widest relative vertices, flat box
      send_directed(pack_xyz(CMAX, CMAX, CMAX), zero3, pack_xyz(CMIN, CMIN, CMIN),
                    pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMIN, CMIN, CMAX));
      send_directed(pack_xyz(CMIN, CMIN, CMIN), pack_xyz(HMAX, HMAX, HMAX),
                    pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMIN, CMAX, CMAX),
                    pack_xyz(CMAX, CMIN, CMAX));
      // largest normal and dot products
      send_directed(pack_xyz(CMAX, CMIN, CMAX), pack_xyz(HMAX, 0, HTOP),
                    pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMAX, CMIN, CMAX),
                    pack_xyz(CMIN, CMIN, CMAX));
      // corner touch counts as overlap; one step further is separated
      send_directed(zero3, pack_xyz(10, 10, 10), pack_xyz(10, 10, 10),
                    pack_xyz(20, 10, 10), pack_xyz(10, 20, 10));
      send_directed(zero3, pack_xyz(10, 10, 10), pack_xyz(10, 10, 11),
                    pack_xyz(20, 10, 11), pack_xyz(10, 20, 11));
      // zero-area triangles: line outside, line through, point in, point out
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(20, 0, 0),
                    pack_xyz(0, 20, 0), pack_xyz(10, 10, 0));
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(-20, 0, 0),
                    pack_xyz(20, 0, 0), pack_xyz(0, 0, 0));
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(3, -2, 1),
                    pack_xyz(3, -2, 1), pack_xyz(3, -2, 1));
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(6, 0, 0),
                    pack_xyz(6, 0, 0), pack_xyz(6, 0, 0));
      // tilted plane past the box corner, touching it, and reversed winding
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(30, 0, 0),
                    pack_xyz(0, 30, 0), pack_xyz(0, 0, 30));
      send_directed(zero3, pack_xyz(10, 10, 10), pack_xyz(30, 0, 0),
                    pack_xyz(0, 30, 0), pack_xyz(0, 0, 30));
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(0, 30, 0),
                    pack_xyz(30, 0, 0), pack_xyz(0, 0, 30));
      // half sizes with the top bit set are still positive
      send_directed(zero3, pack_xyz(HTOP, HTOP, HTOP), pack_xyz(CMAX, 0, 0),
                    pack_xyz(CMAX, 5, 0), pack_xyz(CMAX, 0, 5));
      send_directed(pack_xyz(CMAX, 0, 0), pack_xyz(HTOP, 1, 1), pack_xyz(CMIN, 0, 0),
                    pack_xyz(CMIN, 1, 0), pack_xyz(CMIN, 0, 1));
      // large triangle through a small box, then lifted off a face
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(-1000, -1000, 0),
                    pack_xyz(1000, -1000, 0), pack_xyz(0, 1000, 0));
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(-1000, -1000, 6),
                    pack_xyz(1000, -1000, 6), pack_xyz(0, 1000, 6));
      // beyond the -y face
      send_directed(zero3, pack_xyz(10, 10, 10), pack_xyz(0, -20, 0),
                    pack_xyz(5, -20, 0), pack_xyz(0, -20, 5));
      // nonzero centre, corner touch
      send_directed(pack_xyz(100, 200, -300), pack_xyz(4, 4, 4), pack_xyz(104, 204, -296),
                    pack_xyz(110, 204, -296), pack_xyz(104, 210, -296));
      // sliver near a box edge
      send_directed(zero3, pack_xyz(5, 5, 5), pack_xyz(-3, 14, -20),
                    pack_xyz(14, -3, -20), pack_xyz(12, -1, 20));
   endtask

   // -------------------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off to back up the pipe
   // -------------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int mode_left, tick;
      bit held_off;
      rsp_tready = 1'b0;
      mode       = RX_OPEN;
      mode_left  = 0;
      tick       = 0;
      held_off   = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && sb.requests_noted >= HOLD_AFTER) begin
            // sender keeps offering; input must stall once all stages fill
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         tick++;
         case (mode)
            RX_OPEN:    rsp_tready <= 1'b1;
            RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rsp_tready <= (tick % 4) != 3;
            default:    rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int i = 0; i < RANDOM_ITEMS; i++) offer_request(random_request());
      req_tvalid <= 1'b0;

      // drain, then watch a little longer for stray responses
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

      $display("%0d requests (%0d directed, %0d random) checked in %0d cycles",
               sb.requests_noted, directed_sent, RANDOM_ITEMS, cycle_count);
      $display("responses: %0d overlapping, %0d separated, %0d mismatches",
               sb.overlap_seen, sb.separated_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/tbo_pkg.sv
sv/tbo_prep.sv
sv/tbo_axes.sv
sv/tbo_plane.sv
sv/triangle_box_overlap_test_unit.sv
tb/sv/triangle_box_overlap_test_unit_test.sv
